// ===== rtl/gcdp_pkg.sv =====
// ----------------------------------------------------------------------------
// gcdp_pkg: shared constants and elaboration-time tables
// Field widths, internal fixed-point formats and CORDIC constants for the
// great-circle destination point pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gcdp_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 24;
    localparam int TABN            = 32;
    localparam int NSTG            = (CORDIC_STAGES < TABN) ? CORDIC_STAGES : TABN;
    localparam int WF              = 32;
    localparam int OUT_SHIFT       = WF - ANGLE_FRAC_BITS;

    // payload field widths
    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int HDG_W  = 25;
    localparam int DIST_W = 23;
    localparam int ELAT_W = 24;
    localparam int ELON_W = 26;

    // internal formats: angles in degrees * 2^32, unit vectors in Q30
    localparam int AW = 43;
    localparam int QW = 34;
    localparam int PW = 2 * QW;
    localparam int VW = 36;

    localparam int SQ_STEPS = 32;
    localparam int SC_LAT   = 1 + NSTG;
    localparam int AT_LAT   = 1 + NSTG;
    localparam int MUL_LAT  = 6;
    localparam int LAT      = 1 + SC_LAT + MUL_LAT + SQ_STEPS + AT_LAT + 1;

    localparam logic [63:0]       PI_QTR   = 64'h3243F6A8885A308D;
    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(5124096);
    localparam logic [63:0]       EARTH_RADIUS_KM = 64'd6371;

    localparam logic signed [AW-1:0] DEG_360 = AW'(64'd360 << WF);
    localparam logic signed [AW-1:0] DEG_180 = AW'(64'd180 << WF);
    localparam logic signed [AW-1:0] DEG_90  = AW'(64'd90 << WF);
    localparam logic signed [QW-1:0] QONE    = QW'(64'd1 << 30);

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, dv}) begin
                r = r - {1'b0, dv};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(n * 2^fb / pi_qtr), n below twice pi_qtr
    function automatic logic [63:0] div_pq(input logic [63:0] n, input int fb);
        logic [63:0] q;
        logic [63:0] r;
        if (n >= PI_QTR) begin
            q = 64'd1;
            r = n - PI_QTR;
        end else begin
            q = 64'd0;
            r = n;
        end
        for (int k = 0; k < fb; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= PI_QTR) begin
                r = r - PI_QTR;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bt;
        rem = n;
        res = '0;
        bt  = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bt) begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // atan(2^-i) in degrees * 2^32, from the arctangent series in Q62
    function automatic logic [63:0] atan_entry(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          sh;
        logic        done;
        acc  = '0;
        done = 1'b0;
        if (i == 0) begin
            return 64'd45 << WF;
        end
        for (int k = 0; k < 32; k++) begin
            sh = i * (2 * k + 1);
            if (sh >= 62) begin
                done = 1'b1;
            end
            if (!done) begin
                term = udiv64((64'd1 << 62) >> sh, 64'(2 * k + 1));
                if ((k & 1) != 0) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
        end
        return (div_pq(acc, 40) * 64'd45 + 64'd128) >> 8;
    endfunction

    function automatic logic [63:0] gain_inv_calc();
        logic [63:0] g;
        logic [63:0] a;
        g = 64'd1 << 60;
        for (int i = 0; i < NSTG; i++) begin
            g = g + (g >> (2 * i));
        end
        a = isqrt64(g);
        return udiv64((64'd1 << 60) + (a >> 1), a);
    endfunction

    localparam logic [63:0] GAIN_INV64 = gain_inv_calc();
    localparam logic signed [QW-1:0] GAIN_INV = QW'(GAIN_INV64);
    localparam logic [63:0] KM_FACTOR64 =
        ((div_pq(64'h4000000000000000, 58) * 64'd45) / EARTH_RADIUS_KM) >> 20;
    localparam logic [31:0] KM_FACTOR = 32'(KM_FACTOR64);

    // round half up by 2^30
    function automatic logic signed [PW-1:0] srs30(input logic signed [PW-1:0] v);
        return (v + (PW'(64'sd1) <<< 29)) >>> 30;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gcdp_if.sv =====
// ----------------------------------------------------------------------------
// gcdp_if: request and result channels
// Valid/ready channels carrying start point requests and destination results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcdp_in_if;
    import gcdp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [LAT_W-1:0]    start_lat;
    logic signed [LON_W-1:0]    start_lon;
    logic        [HDG_W-1:0]    heading;
    logic        [DIST_W-1:0]   travel_distance;

    modport source (output valid, start_lat, start_lon, heading, travel_distance,
                    input ready);
    modport sink   (input valid, start_lat, start_lon, heading, travel_distance,
                    output ready);
endinterface

interface gcdp_out_if;
    import gcdp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ELAT_W-1:0]   end_lat;
    logic signed [ELON_W-1:0]   end_lon;

    modport source (output valid, end_lat, end_lon, input ready);
    modport sink   (input valid, end_lat, end_lon, output ready);
endinterface

`default_nettype wire

// ===== rtl/gcdp_sincos.sv =====
// ----------------------------------------------------------------------------
// gcdp_sincos: pipelined rotation-mode cordic
// Reduces an angle to +-90 degrees, then one micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcdp_sincos
(
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [gcdp_pkg::AW-1:0] angle,
    output logic signed [gcdp_pkg::QW-1:0]    cos_q,
    output logic signed [gcdp_pkg::QW-1:0]    sin_q
);

    import gcdp_pkg::*;

    logic signed [AW-1:0] a_reg [0:NSTG];
    logic signed [QW-1:0] x_reg [0:NSTG];
    logic signed [QW-1:0] y_reg [0:NSTG];
    logic                 neg_reg [0:NSTG];

    logic signed [AW-1:0] a_mod;
    logic signed [AW-1:0] a_half;
    logic signed [AW-1:0] a_next;
    logic                 neg_next;

    always_comb
    begin
        a_mod = (angle >= DEG_360) ? angle - DEG_360 : angle;
        if (a_mod > DEG_180)
        begin
            a_half = a_mod - DEG_360;
        end
        else if (a_mod <= -DEG_180)
        begin
            a_half = a_mod + DEG_360;
        end
        else
        begin
            a_half = a_mod;
        end
        // fold into the right half plane, flip the vector at the end
        if (a_half > DEG_90)
        begin
            a_next   = a_half - DEG_180;
            neg_next = 1'b1;
        end
        else if (a_half < -DEG_90)
        begin
            a_next   = a_half + DEG_180;
            neg_next = 1'b1;
        end
        else
        begin
            a_next   = a_half;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0]   <= a_next;
            x_reg[0]   <= GAIN_INV;
            y_reg[0]   <= '0;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < NSTG; i++)
    begin : g_stage
        localparam logic signed [AW-1:0] ROM = AW'(atan_entry(i));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (!a_reg[i][AW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - ROM;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + ROM;
                end
            end
        end
    end

    assign cos_q = neg_reg[NSTG] ? -x_reg[NSTG] : x_reg[NSTG];
    assign sin_q = neg_reg[NSTG] ? -y_reg[NSTG] : y_reg[NSTG];

endmodule

`default_nettype wire

// ===== rtl/gcdp_atan2.sv =====
// ----------------------------------------------------------------------------
// gcdp_atan2: pipelined vectoring-mode cordic
// Angle of (x, y) in degrees * 2^32, in (-180, 180], zero for the origin.
// ----------------------------------------------------------------------------
`default_nettype none

module gcdp_atan2
(
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [gcdp_pkg::VW-1:0] y_in,
    input  wire logic signed [gcdp_pkg::VW-1:0] x_in,
    output logic signed [gcdp_pkg::AW-1:0]    angle
);

    import gcdp_pkg::*;

    logic signed [VW-1:0] x_reg [0:NSTG];
    logic signed [VW-1:0] y_reg [0:NSTG];
    logic signed [AW-1:0] z_reg [0:NSTG];
    logic                 zero_reg [0:NSTG];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            // left half plane: rotate by 180 degrees first
            if (x_in[VW-1])
            begin
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
                z_reg[0] <= y_in[VW-1] ? -DEG_180 : DEG_180;
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NSTG; i++)
    begin : g_stage
        localparam logic signed [AW-1:0] ROM = AW'(atan_entry(i));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ROM;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ROM;
                end
            end
        end
    end

    assign angle = zero_reg[NSTG] ? '0 : z_reg[NSTG];

endmodule

`default_nettype wire

// ===== rtl/great_circle_destination_point_unit.sv =====
// ----------------------------------------------------------------------------
// great_circle_destination_point_unit: spherical direct problem
// Destination latitude and longitude from a start point, bearing and distance.
// ----------------------------------------------------------------------------
// A request on point_in carries start latitude, start longitude, heading and
// travel distance; the result on point_out carries the destination latitude
// and the unwrapped destination longitude. Both are valid/ready channels.
// With 24 cordic stages the pipeline is an input register, three
// sine/cosine cordics of 25 stages in parallel, six multiply stages, a
// 32-stage square root for the latitude cosine, two 25-stage arctangent
// cordics in parallel and an output register.
// Throughput is one request per cycle while the output is not stalled:
// every stage is a register and the whole pipeline advances together.
// When the receiver stalls with a result waiting, the pipeline holds and
// ready drops; nothing is lost or repeated. Empty slots are filled while
// the output is free. Reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_destination_point_unit
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gcdp_in_if.sink    point_in,
    gcdp_out_if.source point_out
);

    import gcdp_pkg::*;

    logic                 en;
    logic [LAT-1:0]       vld_reg;

    // input stage
    logic [DIST_W-1:0]    dist_sat;
    logic [DIST_W+31:0]   ang_prod;
    logic signed [AW-1:0] lat1_reg;
    logic signed [AW-1:0] brg_reg;
    logic signed [AW-1:0] ang_reg;
    logic signed [AW-1:0] lon_reg [0:LAT-2];

    logic signed [QW-1:0] c1, s1, ca, sa, cb, sb;

    // multiply stages
    logic signed [PW-1:0] m1_p1_reg, m1_p2_reg, m1_p3_reg;
    logic signed [QW-1:0] m1_s1_reg, m1_c1_reg, m1_ca_reg;
    logic signed [PW-1:0] m2_p1_reg;
    logic signed [QW-1:0] m2_t_reg, m2_u_reg, m2_s1_reg, m2_c1_reg, m2_ca_reg;
    logic signed [PW-1:0] m3_p1_reg, m3_q_reg, m3_v_reg;
    logic signed [QW-1:0] m3_s1_reg, m3_ca_reg;
    logic signed [PW-1:0] z_wide;
    logic signed [QW-1:0] z_next;
    logic signed [QW-1:0] m4_z_reg, m4_s1_reg, m4_ca_reg;
    logic signed [VW-1:0] m4_y_reg;
    logic signed [PW-1:0] m5_zz_reg, m5_sz_reg;
    logic signed [QW-1:0] m5_z_reg, m5_ca_reg;
    logic signed [VW-1:0] m5_y_reg;

    // square root stages, index 0 is the last multiply stage
    logic [63:0]          sq_rem_reg [0:SQ_STEPS];
    logic [63:0]          sq_res_reg [0:SQ_STEPS];
    logic signed [QW-1:0] zd_reg [0:SQ_STEPS];
    logic signed [VW-1:0] yd_reg [0:SQ_STEPS];
    logic signed [VW-1:0] xd_reg [0:SQ_STEPS];

    logic signed [AW-1:0] lat2;
    logic signed [AW-1:0] dlon;
    logic signed [AW-1:0] lat_rnd;
    logic signed [AW-1:0] lon_rnd;
    logic signed [ELAT_W-1:0] end_lat_reg;
    logic signed [ELON_W-1:0] end_lon_reg;

    assign en             = !vld_reg[LAT-1] || point_out.ready;
    assign point_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], point_in.valid};
        end
    end

    // distance to central angle
    assign dist_sat = (point_in.travel_distance > DIST_MAX) ? DIST_MAX
                                                             : point_in.travel_distance;
    assign ang_prod = (DIST_W+32)'(dist_sat) * (DIST_W+32)'(KM_FACTOR)
                      + ((DIST_W+32)'(1) << 13);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg   <= AW'(point_in.start_lat) <<< OUT_SHIFT;
            lon_reg[0] <= AW'(point_in.start_lon) <<< OUT_SHIFT;
            brg_reg    <= AW'(point_in.heading) << OUT_SHIFT;
            ang_reg    <= AW'(ang_prod >> 14);
            for (int k = 1; k < LAT - 1; k++)
            begin
                lon_reg[k] <= lon_reg[k-1];
            end
        end
    end

    gcdp_sincos u_sc_lat (.clk(clk), .en(en), .angle(lat1_reg), .cos_q(c1), .sin_q(s1));
    gcdp_sincos u_sc_ang (.clk(clk), .en(en), .angle(ang_reg),  .cos_q(ca), .sin_q(sa));
    gcdp_sincos u_sc_brg (.clk(clk), .en(en), .angle(brg_reg),  .cos_q(cb), .sin_q(sb));

    // z = sin(lat1)cos(d) + cos(lat1)sin(d)cos(b), clamped to the unit range
    always_comb
    begin
        z_wide = srs30(m3_p1_reg + m3_q_reg);
        if (z_wide > PW'(QONE))
        begin
            z_next = QONE;
        end
        else if (z_wide < -PW'(QONE))
        begin
            z_next = -QONE;
        end
        else
        begin
            z_next = QW'(z_wide);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_p1_reg <= PW'(s1) * PW'(ca);
            m1_p2_reg <= PW'(sa) * PW'(cb);
            m1_p3_reg <= PW'(sb) * PW'(sa);
            m1_s1_reg <= s1;
            m1_c1_reg <= c1;
            m1_ca_reg <= ca;

            m2_p1_reg <= m1_p1_reg;
            m2_t_reg  <= QW'(srs30(m1_p2_reg));
            m2_u_reg  <= QW'(srs30(m1_p3_reg));
            m2_s1_reg <= m1_s1_reg;
            m2_c1_reg <= m1_c1_reg;
            m2_ca_reg <= m1_ca_reg;

            m3_p1_reg <= m2_p1_reg;
            m3_q_reg  <= PW'(m2_c1_reg) * PW'(m2_t_reg);
            m3_v_reg  <= PW'(m2_u_reg) * PW'(m2_c1_reg);
            m3_s1_reg <= m2_s1_reg;
            m3_ca_reg <= m2_ca_reg;

            m4_z_reg  <= z_next;
            m4_y_reg  <= VW'(srs30(m3_v_reg));
            m4_s1_reg <= m3_s1_reg;
            m4_ca_reg <= m3_ca_reg;

            m5_zz_reg <= PW'(m4_z_reg) * PW'(m4_z_reg);
            m5_sz_reg <= PW'(m4_s1_reg) * PW'(m4_z_reg);
            m5_z_reg  <= m4_z_reg;
            m5_ca_reg <= m4_ca_reg;
            m5_y_reg  <= m4_y_reg;

            // radicand 1 - z^2 and the longitude denominator
            sq_rem_reg[0] <= (64'd1 << 60) - 64'(m5_zz_reg);
            sq_res_reg[0] <= '0;
            zd_reg[0]     <= m5_z_reg;
            yd_reg[0]     <= m5_y_reg;
            xd_reg[0]     <= VW'(m5_ca_reg) - VW'(srs30(m5_sz_reg));
        end
    end

    // one result bit per stage
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zd_reg[j+1] <= zd_reg[j];
                yd_reg[j+1] <= yd_reg[j];
                xd_reg[j+1] <= xd_reg[j];
                if (sq_rem_reg[j] >= sq_res_reg[j] + BIT)
                begin
                    sq_rem_reg[j+1] <= sq_rem_reg[j] - (sq_res_reg[j] + BIT);
                    sq_res_reg[j+1] <= (sq_res_reg[j] >> 1) + BIT;
                end
                else
                begin
                    sq_rem_reg[j+1] <= sq_rem_reg[j];
                    sq_res_reg[j+1] <= sq_res_reg[j] >> 1;
                end
            end
        end
    end

    gcdp_atan2 u_at_lat
    (
        .clk   (clk),
        .en    (en),
        .y_in  (VW'(zd_reg[SQ_STEPS])),
        .x_in  (VW'(sq_res_reg[SQ_STEPS])),
        .angle (lat2)
    );

    gcdp_atan2 u_at_lon
    (
        .clk   (clk),
        .en    (en),
        .y_in  (yd_reg[SQ_STEPS]),
        .x_in  (xd_reg[SQ_STEPS]),
        .angle (dlon)
    );

    assign lat_rnd = (lat2 + (AW'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    assign lon_rnd = (lon_reg[LAT-2] + dlon + (AW'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            end_lat_reg <= lat_rnd[ELAT_W-1:0];
            end_lon_reg <= lon_rnd[ELON_W-1:0];
        end
    end

    assign point_out.valid   = vld_reg[LAT-1];
    assign point_out.end_lat = end_lat_reg;
    assign point_out.end_lon = end_lon_reg;

endmodule

`default_nettype wire
